// ===== rtl/core/tariff_zone_selector_unit_assert.svh =====
// Assertion macros used by the tariff zone selector checker
`ifndef TARIFF_ZONE_SELECTOR_UNIT_ASSERT_SVH
`define TARIFF_ZONE_SELECTOR_UNIT_ASSERT_SVH

// Antecedent in this cycle, consequent in the next cycle
`define TZS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent and consequent in the same cycle
`define TZS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tzs_pkg.sv =====
// Types and constants of the tariff zone selector
`default_nettype none

package tzs_pkg;

  // Time constants
  localparam logic [15:0] MINS_PER_DAY = 16'd1440;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int MINUTE_W = 11;
  localparam int START_W  = 16;
  localparam int SLOT_W   = 4;
  localparam int ZONE_W   = 3;

  // Intermediate widths: t/60, t/60 in 32-minute blocks, whole days
  localparam int MINS_W  = 27;
  localparam int BLOCK_W = 22;
  localparam int DAYS_W  = 17;

  // Reciprocals for exact division by 60 (shift 37) and by 45 (shift 28)
  localparam logic [31:0] RECIP_60   = 32'h8888_8889;
  localparam logic [31:0] RECIP_45   = 32'd5965233;
  // A day is 45 blocks of 32 minutes
  localparam logic [5:0]  DAY_BLOCKS = 6'd45;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ZONE_COUNT = 2'd0;
  localparam logic [1:0] REG_STARTS_LO  = 2'd1;
  localparam logic [1:0] REG_STARTS_HI  = 2'd2;
  localparam logic [1:0] REG_ZONE_MAP   = 2'd3;

  // Operation of the shared multiplier unit
  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_MIN,
    DIV_DAY,
    DIV_REM
  } tzs_div_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_DAY,
    ST_REM,
    ST_SCAN,
    ST_FINISH
  } tzs_state_t;

  // Result of one window test
  typedef struct packed {
    logic                 match;
    logic [START_W-1:0]   early_hi;
  } tzs_win_t;

endpackage

`default_nettype wire

// ===== rtl/core/tzs_minute_unit.sv =====
// Shared multiplier unit: seconds to minute of day by reciprocal products
`default_nettype none

module tzs_minute_unit import tzs_pkg::*; (
  input  wire logic                clk,
  input  wire tzs_div_op_t         op,
  input  wire logic [TIME_W-1:0]   din,
  output logic      [MINUTE_W-1:0] minute
);

  logic [TIME_W-1:0]   time_r;
  logic [MINS_W-1:0]   mins_r;
  logic [DAYS_W-1:0]   days_r;
  logic [MINUTE_W-1:0] minute_r;

  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         product;
  logic [BLOCK_W-1:0]  blocks;
  logic [BLOCK_W-1:0]  day_blocks;
  logic [BLOCK_W-1:0]  block_rem;

  // One multiplier: t * recip(60), then (minutes / 32) * recip(45)
  always_comb begin
    blocks     = mins_r[MINS_W-1:5];
    mul_a      = (op == DIV_DAY) ? {10'd0, blocks} : time_r;
    mul_b      = (op == DIV_DAY) ? RECIP_45 : RECIP_60;
    product    = 64'(mul_a) * 64'(mul_b);
    day_blocks = {5'd0, days_r} * {16'd0, DAY_BLOCKS};
    block_rem  = blocks - day_blocks;
  end

  // Minute of day = (blocks mod 45) * 32 + low five bits of t / 60
  always_ff @(posedge clk) begin
    case (op)
      DIV_LOAD: begin
        time_r <= din;
      end
      DIV_MIN: begin
        mins_r <= product[63:37];
      end
      DIV_DAY: begin
        days_r <= product[44:28];
      end
      DIV_REM: begin
        minute_r <= {block_rem[5:0], mins_r[4:0]};
      end
      default: begin
      end
    endcase
  end

  assign minute = minute_r;

endmodule

`default_nettype wire

// ===== rtl/core/tzs_window_cmp.sv =====
// Tests one start-minute window, with wrap at midnight
`default_nettype none

module tzs_window_cmp import tzs_pkg::*; (
  input  wire logic [MINUTE_W-1:0] minute,
  input  wire logic [START_W-1:0]  start_a,
  input  wire logic [START_W-1:0]  start_b,
  input  wire logic [START_W-1:0]  early_hi_in,
  output tzs_win_t                 win
);

  logic [START_W-1:0] m16;
  logic               wrap;
  logic [START_W-1:0] hi;

  // A window ending below its start runs to midnight; its early part is kept
  always_comb begin
    m16          = {5'd0, minute};
    wrap         = (start_b < start_a);
    hi           = wrap ? MINS_PER_DAY : start_b;
    win.early_hi = wrap ? start_b : early_hi_in;
    win.match    = ((m16 >= start_a) && (m16 < hi)) || (m16 < win.early_hi);
  end

endmodule

`default_nettype wire

// ===== rtl/core/tariff_zone_selector_unit.sv =====
// Tariff zone selector top level: config registers, sequencer, output stage
//
//   channel | direction | handshake          | payload
//   in      | request   | in_valid/in_stall  | in_time_seconds
//   out     | result    | out_valid/out_stall| out_zone, out_slot, out_zone_changed
//   cfg     | APB write | psel/penable/pready| 64-bit registers at 8*i
//
// An item passes through these steps from accept to result: the t/60 and day
// reciprocal products on the shared multiplier, the day remainder, a scan of
// the slots one by one up to the matched slot (one to eight), and the load of
// the output register. in_stall is high until that load; the next request is
// taken in the cycle after it. A stalled result holds the load back.
// Synchronous reset: zone count 1, tables and current zone 0, no result held.
`default_nettype none

module tariff_zone_selector_unit import tzs_pkg::*; #(
  parameter int MAX_ZONES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [TIME_W-1:0] in_time_seconds,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ZONE_W-1:0]      out_zone,
  output logic [SLOT_W-1:0]      out_slot,
  output logic                   out_zone_changed,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [4:0]        cfg_paddr,
  input  wire logic [63:0]       cfg_pwdata,
  output logic [63:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam logic [7:0]        MaxZones8 = 8'(MAX_ZONES);
  localparam logic [SLOT_W-1:0] MaxZones4 = SLOT_W'(MAX_ZONES);

  // Configuration registers
  logic [7:0]  zone_count_r;
  logic [63:0] starts_lo_r;
  logic [63:0] starts_hi_r;
  logic [63:0] zone_map_r;

  // Sequencer and datapath state
  tzs_state_t          state_r, state_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [START_W-1:0]  early_hi_r, early_hi_nxt;
  logic [ZONE_W-1:0]   current_zone_r;

  // Output register
  logic                out_valid_r;
  logic [ZONE_W-1:0]   out_zone_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_changed_r;

  tzs_div_op_t         div_op;
  logic [MINUTE_W-1:0] minute;
  tzs_win_t            win;

  logic                cfg_wr;
  logic [1:0]          cfg_idx;
  logic                in_acc;
  logic                out_load;
  logic [SLOT_W-1:0]   count_clamp;
  logic [SLOT_W-1:0]   count_eff;
  logic [127:0]        starts_all;
  logic [2:0]          a_idx;
  logic [2:0]          b_idx;
  logic [START_W-1:0]  start_a;
  logic [START_W-1:0]  start_b;
  logic [2:0]          map_idx;
  logic [7:0]          raw_byte;
  logic [ZONE_W-1:0]   zone_new;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r <= 8'd1;
      starts_lo_r  <= '0;
      starts_hi_r  <= '0;
      zone_map_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ZONE_COUNT: zone_count_r <= cfg_pwdata[7:0];
        REG_STARTS_LO:  starts_lo_r  <= cfg_pwdata;
        REG_STARTS_HI:  starts_hi_r  <= cfg_pwdata;
        REG_ZONE_MAP:   zone_map_r   <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ZONE_COUNT: cfg_prdata = {56'd0, zone_count_r};
      REG_STARTS_LO:  cfg_prdata = starts_lo_r;
      REG_STARTS_HI:  cfg_prdata = starts_hi_r;
      REG_ZONE_MAP:   cfg_prdata = zone_map_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // Clamped zone count, at least one slot
  assign count_clamp = (zone_count_r > MaxZones8) ? MaxZones4 : zone_count_r[SLOT_W-1:0];
  assign count_eff   = (count_clamp == '0) ? SLOT_W'(1) : count_clamp;

  // Window bounds for the slot under test
  assign starts_all = {starts_hi_r, starts_lo_r};
  assign a_idx      = 3'(slot_r - SLOT_W'(1));
  assign b_idx      = slot_r[2:0];
  assign start_a    = starts_all[a_idx*START_W +: START_W];
  assign start_b    = starts_all[b_idx*START_W +: START_W];

  // Zone lookup for the chosen slot
  assign map_idx  = 3'(slot_r - SLOT_W'(1));
  assign raw_byte = zone_map_r[map_idx*8 +: 8];
  assign zone_new = raw_byte[ZONE_W-1:0] - ZONE_W'(1);

  tzs_minute_unit u_minute (
    .clk    (clk),
    .op     (div_op),
    .din    (in_time_seconds),
    .minute (minute)
  );

  tzs_window_cmp u_window (
    .minute      (minute),
    .start_a     (start_a),
    .start_b     (start_b),
    .early_hi_in (early_hi_r),
    .win         (win)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // Sequencer next state and unit control
  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    early_hi_nxt = early_hi_r;
    div_op       = DIV_IDLE;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          div_op    = DIV_LOAD;
          state_nxt = ST_MIN;
        end
      end
      ST_MIN: begin
        div_op    = DIV_MIN;
        state_nxt = ST_DAY;
      end
      ST_DAY: begin
        div_op    = DIV_DAY;
        state_nxt = ST_REM;
      end
      ST_REM: begin
        div_op       = DIV_REM;
        slot_nxt     = SLOT_W'(1);
        early_hi_nxt = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        // Slot count reached or window hit: slot_r is the answer
        if (slot_r >= count_eff || win.match) begin
          state_nxt = ST_FINISH;
        end else begin
          early_hi_nxt = win.early_hi;
          slot_nxt     = slot_r + SLOT_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    early_hi_r <= early_hi_nxt;
  end

  // Current zone tracks the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_zone_r <= '0;
    end else if (out_load) begin
      current_zone_r <= zone_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_zone_r    <= zone_new;
      out_slot_r    <= slot_r;
      out_changed_r <= (zone_new != current_zone_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_zone         = out_zone_r;
  assign out_slot         = out_slot_r;
  assign out_zone_changed = out_changed_r;

endmodule

`default_nettype wire

// ===== rtl/core/tzs_checker.sv =====
// Port-level checker for the tariff zone selector, bound to the top level
`default_nettype none

`include "tariff_zone_selector_unit_assert.svh"

module tzs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_zone,
  input wire logic [3:0]  out_slot,
  input wire logic        out_zone_changed
);

  // A held result stays valid
  `TZS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // A held result keeps its payload
  `TZS_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(out_zone) && $stable(out_slot) && $stable(out_zone_changed),
    "result payload changed while stalled")

  // An accepted request keeps the block busy for the following cycles
  `TZS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall,
    "block ready right after a request")

  // A new result appears only at the end of a busy period
  `TZS_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall) && !in_stall,
    "result without preceding work")

  // Slot always lies in one to eight
  `TZS_ASSERT_SAME(a_slot_range, out_valid, out_slot != 4'd0 && out_slot <= 4'd8,
    "slot out of range")

endmodule

bind tariff_zone_selector_unit tzs_checker u_tzs_checker (.*);

`default_nettype wire

// ===== tb/zone_result_checker.sv =====
// Result checker for the tariff zone selector: mirrors the registers, predicts and compares
module zone_result_checker import tzs_pkg::*; #(
  parameter int MAX_ZONES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [TIME_W-1:0] in_time_seconds,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ZONE_W-1:0] out_zone,
  input  logic [SLOT_W-1:0] out_slot,
  input  logic              out_zone_changed,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [4:0]        cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic [SLOT_W-1:0] slot;
    logic              changed;
  } zone_result_t;

  // Shadow copy of the register file and the stored zone
  logic [7:0]        zone_count;
  logic [127:0]      start_table;  // entries 0..7, 16 bits each, entry 0 lowest
  logic [63:0]       zone_map;
  logic [ZONE_W-1:0] current_zone;

  zone_result_t expected_zones[$];
  zone_result_t got, want;

  // Minute of day, window scan, map lookup; updates the stored zone
  function automatic zone_result_t select_zone(input logic [TIME_W-1:0] t);
    int unsigned minute, limit, lo, hi, early_hi;
    int slot;
    logic [7:0] raw;
    zone_result_t r;
    minute = (t / 32'd60) % 32'd1440;
    limit = (zone_count > MAX_ZONES) ? MAX_ZONES : zone_count;
    early_hi = 0;
    for (slot = 1; slot < limit; slot++) begin
      lo = start_table[16*(slot-1) +: 16];
      hi = start_table[16*slot +: 16];
      // descending pair wraps at midnight; its early part stays live for later slots
      if (hi < lo) begin
        early_hi = hi;
        hi = 1440;
      end
      if ((minute >= lo && minute < hi) || minute < early_hi) break;
    end
    raw = zone_map[8*(slot-1) +: 8];
    r.zone = raw[ZONE_W-1:0] - 3'd1;  // zero byte wraps to zone 7
    r.slot = slot[SLOT_W-1:0];
    r.changed = (r.zone != current_zone);
    current_zone = r.zone;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned expected_val,
                                        input int unsigned actual_val);
    if (expected_val != actual_val) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected_val,
               actual_val);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      zone_count = 8'd1;
      start_table = '0;
      zone_map = '0;
      current_zone = '0;
      expected_zones.delete();
      fail_count = 0;
    end else begin
      // register writes on the access phase
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_ZONE_COUNT: zone_count = cfg_pwdata[7:0];
          REG_STARTS_LO:  start_table[63:0] = cfg_pwdata;
          REG_STARTS_HI:  start_table[127:64] = cfg_pwdata;
          REG_ZONE_MAP:   zone_map = cfg_pwdata;
          default: ;
        endcase
      end

      // result side
      if (out_valid && !out_stall) begin
        got = {out_zone, out_slot, out_zone_changed};
        if (expected_zones.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual zone %0d slot %0d changed %0d",
                   $time, got.zone, got.slot, got.changed);
        end else begin
          want = expected_zones.pop_front();
          compare_field("zone", want.zone, got.zone);
          compare_field("slot", want.slot, got.slot);
          compare_field("zone_changed", want.changed, got.changed);
        end
      end

      // request side
      if (in_valid && !in_stall)
        expected_zones.push_back(select_zone(in_time_seconds));
    end
    pending = expected_zones.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the tariff zone selector testbench: clock, reset, stimulus, watchdog and verdict
module testbench;
  import tzs_pkg::*;

  localparam int MAX_ZONES     = 8;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake of any kind
  localparam int RANDOM_ROUNDS = 12;
  localparam int ROUND_ITEMS   = 160;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [TIME_W-1:0] in_time_seconds;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ZONE_W-1:0] out_zone;
  logic [SLOT_W-1:0] out_slot;
  logic              out_zone_changed;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [4:0]        cfg_paddr;
  logic [63:0]       cfg_pwdata;
  logic [63:0]       cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic [127:0] start_table = '0;  // start minutes last written

  tariff_zone_selector_unit #(.MAX_ZONES(MAX_ZONES)) uut (.*);

  zone_result_checker #(.MAX_ZONES(MAX_ZONES)) checker_i (.*);

  always #4 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < receiver_stall_pct);

  // watchdog: any accepted request, result or register access restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_time(input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_time_seconds <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {index, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic configure(input logic [7:0] count, input logic [127:0] starts,
                           input logic [63:0] map);
    drain_results();
    write_reg(REG_ZONE_COUNT, {56'd0, count});
    write_reg(REG_STARTS_LO, starts[63:0]);
    write_reg(REG_STARTS_HI, starts[127:64]);
    write_reg(REG_ZONE_MAP, map);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    start_table = starts;
  endtask

  // mostly minutes right at a window edge, some anywhere, some raw counter values
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned roll, entry;
    int minute;
    roll = $urandom_range(99);
    if (roll < 15) return $urandom();
    if (roll < 30) begin
      minute = $urandom_range(1439);
    end else begin
      entry = $urandom_range(7);
      minute = start_table[16*entry +: 16];
      minute = (minute + $urandom_range(2) + 1439) % 1440;
    end
    return $urandom_range(49709) * 32'd86400 + minute * 60 + $urandom_range(59);
  endfunction

  task automatic random_config(input int round);
    logic [7:0]   count;
    logic [127:0] starts;
    logic [63:0]  map;
    int m, i, rot;
    int unsigned mode;
    case (round % 6)
      0: count = 8'd0;
      1: count = 8'd1;
      2: count = MAX_ZONES;
      3: count = 8'hFF;
      4: count = $urandom_range(MAX_ZONES, 2);
      default: count = $urandom_range(255);
    endcase
    // ascending start minutes, possibly repeated
    m = $urandom_range(180);
    for (i = 0; i < 8; i++) begin
      starts[16*i +: 16] = m;
      m += $urandom_range(180);
    end
    mode = $urandom_range(9);
    if (mode == 6 || mode == 7) begin
      // rotate so one pair wraps past midnight
      rot = $urandom_range(7, 1);
      starts = (starts >> (16*rot)) | (starts << (16*(8-rot)));
    end else if (mode == 8) begin
      starts = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else if (mode == 9) begin
      // one start beyond the end of the day, used raw
      i = $urandom_range(7);
      starts[16*i +: 16] = $urandom_range(65535, 1440);
    end
    map = {$urandom(), $urandom()};
    if ($urandom_range(1)) begin
      i = $urandom_range(7);
      map[8*i +: 8] = 8'h00;
    end
    configure(count, starts, map);
  endtask

  initial begin
    int round, n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_time_seconds <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one zone, zero map byte gives zone 7
    send_time(32'd0);
    send_time(32'hFFFF_FFFF);

    // zone count zero: slot 1 always
    configure(8'd0, {64'h0000_0000_0000_0010, 64'h0000_0000_0005_0000},
              64'h0807_0605_0403_0201);
    send_time(32'd59);
    send_time(32'd60);

    // full table of ascending windows; minute 1260 and later matches nothing
    configure(MAX_ZONES, {64'h04EC_0438_0384_02D0, 64'h021C_0168_00B4_0000},
              64'h0807_0605_0403_0201);
    send_time(32'd10740);
    send_time(32'd10800);
    send_time(32'd75599);
    send_time(32'd75600);
    send_time(32'd86399);
    send_time(32'd86400);

    // clamped count, wrapping window, raw start past end of day, zero and 0xFF bytes
    configure(8'hFF, {64'h059F_0064_FFFF_03B6, 64'h0384_012C_04B0_0258},
              64'h00FF_3412_7809_0A00);
    send_time(32'd100 * 60);
    send_time(32'd1300 * 60 + 7);
    send_time(32'd599 * 60);
    send_time(32'd920 * 60);
    send_time(32'd1000 * 60);
    send_time(32'd1439 * 60 + 59);
    send_time(32'hFFFF_FFFF);

    // random rounds, each with its own settings and idling pattern
    for (round = 0; round < RANDOM_ROUNDS; round++) begin
      random_config(round);
      case (round % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 71;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 71;
        end
        default: begin
          sender_idle_pct = 26;
          receiver_stall_pct = 26;
        end
      endcase
      for (n = 0; n < ROUND_ITEMS; n++)
        send_time(pick_time());
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tzs_pkg.sv
rtl/core/tzs_minute_unit.sv
rtl/core/tzs_window_cmp.sv
rtl/core/tariff_zone_selector_unit.sv
rtl/core/tzs_checker.sv
tb/zone_result_checker.sv
tb/testbench.sv
